[sv/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types and constants for the text-to-integer converter.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int MAX_BASE = 16;
  localparam int DIGIT_W  = $clog2(MAX_BASE);
  localparam int LEN_W    = 5;
  localparam int ALPHA_W  = 64;
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  // Reset configuration: decimal digits "0123456789".
  localparam logic [LEN_W-1:0]   RST_BASE_LENGTH   = 5'd10;
  localparam logic [ALPHA_W-1:0] RST_ALPHABET_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0] RST_ALPHABET_HIGH = 64'h0000_0000_0000_3938;

  // Character codes the parser looks for.
  localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_CTRL_LO  = 8'd7;
  localparam logic [CHAR_W-1:0] CHAR_CTRL_HI  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PLUS     = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_HIGH_MIN = 8'd128;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_CTRL,
    PH_SIGN,
    PH_DIGIT,
    PH_STOP
  } parse_phase_t;

endpackage

[sv/text_to_integer_any_base_core.sv]
// ----------------------------------------------------------------------------
// text_to_integer_any_base_core
// Streaming string-to-integer converter with a configurable digit alphabet.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and keeps taking one per cycle for
// as long as results are drained. A character passes an input register and is
// then parsed combinationally (one bank of alphabet compares and one
// multiply-add by the radix); the result for a string is loaded into the
// output register when its last character leaves the input register. The
// alphabet validity flag is recomputed from the configuration registers and
// held in its own register, so a write reaches it through both registers.
module text_to_integer_any_base_core
  import tti_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ALPHA_W-1:0]   cfg_data,
  // Character stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] ch
  input  logic                 s_tlast,   // last
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // [31:0] value
  output logic                 m_tuser    // [0] base_invalid
);

  // Configuration registers.
  logic [LEN_W-1:0]   base_length;
  logic [ALPHA_W-1:0] alphabet_low;
  logic [ALPHA_W-1:0] alphabet_high;
  logic               base_bad;
  logic               base_bad_next;
  logic [CHAR_W-1:0]  alpha_chars [MAX_BASE];

  // Input register.
  logic               in_valid;
  logic [CHAR_W-1:0]  in_ch;
  logic               in_last;

  // Parser state.
  parse_phase_t       phase;
  parse_phase_t       phase_next;
  logic               negative;
  logic               negative_next;
  logic [VALUE_W-1:0] accumulator;
  logic [VALUE_W-1:0] accumulator_next;

  // Per-character work.
  parse_phase_t       ph;
  logic               neg_c;
  logic [VALUE_W-1:0] acc_c;
  logic               taken;
  logic               digit_hit;
  logic [DIGIT_W-1:0] digit_val;
  logic [VALUE_W-1:0] result_value;
  logic               advance;
  logic               proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length   <= RST_BASE_LENGTH;
      alphabet_low  <= RST_ALPHABET_LOW;
      alphabet_high <= RST_ALPHABET_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_LENGTH:   base_length   <= cfg_data[LEN_W-1:0];
        CFG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        CFG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      if (k < 8) begin
        alpha_chars[k] = alphabet_low[k*CHAR_W +: CHAR_W];
      end else begin
        alpha_chars[k] = alphabet_high[(k-8)*CHAR_W +: CHAR_W];
      end
    end
  end

  // Validity check: base length range, then bad characters and duplicates in the used part of the alphabet.
  always_comb begin
    base_bad_next = (base_length < LEN_W'(2)) || (base_length > LEN_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (i < int'(base_length)) begin
        if (alpha_chars[i] == CHAR_PLUS || alpha_chars[i] == CHAR_MINUS ||
            alpha_chars[i] <= CHAR_SPACE || alpha_chars[i] >= CHAR_HIGH_MIN) begin
          base_bad_next = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (j < int'(base_length) && alpha_chars[j] == alpha_chars[i]) begin
            base_bad_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_bad <= 1'b0;
    end else begin
      base_bad <= base_bad_next;
    end
  end

  // Handshake and input register.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign proc     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Digit lookup: the lowest matching alphabet position wins.
  always_comb begin
    digit_hit = 1'b0;
    digit_val = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if (i < int'(base_length) && alpha_chars[i] == in_ch) begin
        digit_hit = 1'b1;
        digit_val = DIGIT_W'(i);
      end
    end
  end

  // One character may fall through several phases in the same cycle.
  always_comb begin
    ph    = phase;
    neg_c = negative;
    acc_c = accumulator;
    taken = 1'b0;
    if (ph == PH_SPACE) begin
      if (in_ch == CHAR_SPACE) begin
        taken = 1'b1;
      end else begin
        ph = PH_CTRL;
      end
    end
    if (!taken && ph == PH_CTRL) begin
      if (in_ch >= CHAR_CTRL_LO && in_ch <= CHAR_CTRL_HI) begin
        taken = 1'b1;
      end else begin
        ph = PH_SIGN;
      end
    end
    if (!taken && ph == PH_SIGN) begin
      priority if (in_ch == CHAR_PLUS) begin
        taken = 1'b1;
      end else if (in_ch == CHAR_MINUS) begin
        neg_c = !neg_c;
        taken = 1'b1;
      end else begin
        ph = PH_DIGIT;
      end
    end
    if (!taken && ph == PH_DIGIT) begin
      if (in_ch != CHAR_NUL && digit_hit) begin
        acc_c = accumulator * VALUE_W'(base_length) + VALUE_W'(digit_val);
      end else begin
        ph = PH_STOP;
      end
    end

    result_value = neg_c ? (VALUE_W'(0) - acc_c) : acc_c;
    if (base_bad) begin
      result_value = '0;
    end

    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    if (proc) begin
      if (in_last) begin
        phase_next       = PH_SPACE;
        negative_next    = 1'b0;
        accumulator_next = '0;
      end else begin
        phase_next       = ph;
        negative_next    = neg_c;
        accumulator_next = acc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      m_tdata <= result_value;
      m_tuser <= base_bad;
    end
  end

endmodule

[sv/tti_checker.sv]
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks for the text-to-integer converter.
// ----------------------------------------------------------------------------
module tti_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [31:0]          m_tdata,
  input logic                 m_tuser
);

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An invalid alphabet always reports zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("invalid alphabet gave a nonzero value");

  // With the output empty the character side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // A new result follows an accepted last character.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a last character");

endmodule

bind text_to_integer_any_base_core tti_checker u_tti_checker (.*);
